[hdl/atm_pkg.sv]
// Package of shared constants, payload types and control structs for the trimmed mean filter.
`timescale 1ns / 1ps

package atm_pkg;

    localparam int APERTURE  = 5;
    localparam int HALF      = APERTURE / 2;
    localparam int WIN       = 2 * HALF + 1;
    localparam int NWIN      = WIN * WIN;
    localparam int RING      = WIN + 1;
    localparam int MAX_WIDTH = 512;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 10;
    localparam int TRIM_W    = 4;
    localparam int MIN_DIM   = 3;
    localparam int TRIM_MAX  = (NWIN - 1) / 2;

    localparam int RING_W    = $clog2(RING);
    localparam int MEM_DEPTH = RING * MAX_WIDTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int WPOS_W    = $clog2(WIN);
    localparam int IDX_W     = $clog2(NWIN);
    localparam int CNT_W     = $clog2(NWIN + 1);
    localparam int SUM_W     = $clog2(NWIN * 255 + 1);
    localparam int DIV_W     = $clog2(NWIN + 1);
    localparam int DIFF_W    = $clog2(HALF * MAX_WIDTH + HALF + 2);

    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_HALF_TRIM     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd2;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             end_of_frame;
    } out_item_t;

    typedef struct packed {
        logic              accept;
        logic              win_clear;
        logic              rd_en;
        logic [WPOS_W-1:0] wy;
        logic [WPOS_W-1:0] wx;
        logic              sum_clear;
        logic              sum_en;
        logic [IDX_W-1:0]  sum_idx;
        logic              div_start;
        logic              out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit_req;
        logic div_busy;
        logic out_full;
    } dp_stat_t;

endpackage

[hdl/atm_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module atm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [atm_pkg::SUM_W-1:0] dividend,
    input  logic [atm_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic [atm_pkg::SUM_W-1:0] quotient
);
    import atm_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [DIV_W:0]    shifted;
    logic              fits;
    logic [DIV_W:0]    diff;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= STEP_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so its top bit is dropped safely.
            rem_reg <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[hdl/atm_datapath.sv]
// Datapath: registers, position counters, row store, sorted window, trimmed sum and output.
`timescale 1ns / 1ps

module atm_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [atm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    input  atm_pkg::in_item_t           req,
    output atm_pkg::out_item_t          res,
    output logic                        res_valid,
    input  logic                        res_ready,
    input  atm_pkg::ctrl_cmd_t          cmd,
    output atm_pkg::dp_stat_t           stat
);
    import atm_pkg::*;

    localparam int SW   = DIM_W + 2;
    localparam int RT_W = RING_W + 2;

    logic [TRIM_W-1:0] half_trim_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;

    logic [DIM_W-1:0]  in_col_reg;
    logic [DIM_W-1:0]  in_row_reg;
    logic [RING_W-1:0] in_ring_reg;
    logic [DIM_W-1:0]  out_col_reg;
    logic [DIM_W-1:0]  out_row_reg;
    logic [RING_W-1:0] out_ring_reg;
    logic [DIFF_W-1:0] diff_reg;

    logic [PIX_W-1:0]  mem [MEM_DEPTH];
    logic [PIX_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;

    logic [PIX_W-1:0]  win_reg [NWIN];
    logic [PIX_W-1:0]  win_next [NWIN];
    logic              gt [NWIN];
    logic [CNT_W-1:0]  fill_reg;

    logic [SUM_W-1:0]  sum_reg;
    logic              res_valid_reg;
    out_item_t         res_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [DIM_W-1:0]     eff_w;
    logic [DIM_W-1:0]     eff_h;
    logic [TRIM_W-1:0]    trim;
    logic [DIFF_W-1:0]    lag;
    logic                 frame_in_done;
    logic                 push;
    logic                 last_out;
    logic                 in_col_wrap;
    logic                 out_col_wrap;

    logic signed [SW-1:0]   ys;
    logic signed [SW-1:0]   xs;
    logic [DIM_W-1:0]       ycl;
    logic [DIM_W-1:0]       xcl;
    logic signed [RT_W-1:0] rt;
    logic [RING_W-1:0]      rd_ring;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;

    logic [IDX_W-1:0]  keep_lo;
    logic [IDX_W-1:0]  keep_hi;
    logic              keep;
    logic [DIV_W-1:0]  divisor;
    logic              div_busy;
    logic [SUM_W-1:0]  quotient;

    // Configuration port
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_trim_reg <= '0;
            width_reg     <= DIM_W'(MAX_WIDTH);
            height_reg    <= DIM_W'(MAX_WIDTH);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_HALF_TRIM:     half_trim_reg <= pwdata[TRIM_W-1:0];
                REG_ACTIVE_WIDTH:  width_reg     <= pwdata[DIM_W-1:0];
                REG_ACTIVE_HEIGHT: height_reg    <= pwdata[DIM_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_HALF_TRIM:     prdata = 32'(half_trim_reg);
            REG_ACTIVE_WIDTH:  prdata = 32'(width_reg);
            REG_ACTIVE_HEIGHT: prdata = 32'(height_reg);
            default:           prdata = '0;
        endcase
    end

    // Effective geometry and trim
    always_comb
    begin
        if (width_reg < DIM_W'(MIN_DIM))
        begin
            eff_w = DIM_W'(MIN_DIM);
        end
        else if (width_reg > DIM_W'(MAX_WIDTH))
        begin
            eff_w = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
    end

    assign eff_h = (height_reg < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) : height_reg;
    assign trim  = (half_trim_reg > TRIM_W'(TRIM_MAX)) ? TRIM_W'(TRIM_MAX) : half_trim_reg;
    assign lag   = DIFF_W'(HALF) * DIFF_W'(eff_w) + DIFF_W'(HALF);

    assign frame_in_done = in_row_reg >= eff_h;
    assign push          = cmd.accept && (req.cmd == CMD_PUSH) && !frame_in_done;
    assign last_out      = (out_row_reg == eff_h - 1'b1) && (out_col_reg == eff_w - 1'b1);
    assign in_col_wrap   = (in_col_reg + 1'b1) >= eff_w;
    assign out_col_wrap  = (out_col_reg + 1'b1) >= eff_w;

    // diff_reg counts pushed pixels not yet matched by an output.
    assign stat.emit_req = (req.cmd == CMD_PUSH) ? (!frame_in_done && diff_reg >= lag)
                                                 : frame_in_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ring_reg <= '0;
            diff_reg     <= '0;
        end
        else if (cfg_wr && (reg_idx == REG_ACTIVE_WIDTH || reg_idx == REG_ACTIVE_HEIGHT))
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ring_reg <= '0;
            diff_reg     <= '0;
        end
        else if (push)
        begin
            diff_reg <= diff_reg + 1'b1;
            if (in_col_wrap)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= in_row_reg + 1'b1;
                in_ring_reg <= (in_ring_reg == RING_W'(RING - 1)) ? '0 : in_ring_reg + 1'b1;
            end
            else
            begin
                in_col_reg <= in_col_reg + 1'b1;
            end
        end
        else if (cmd.out_load)
        begin
            if (last_out)
            begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_ring_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_ring_reg <= '0;
                diff_reg     <= '0;
            end
            else
            begin
                diff_reg <= diff_reg - 1'b1;
                if (out_col_wrap)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + 1'b1;
                    out_ring_reg <= (out_ring_reg == RING_W'(RING - 1)) ? '0
                                                                       : out_ring_reg + 1'b1;
                end
                else
                begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    // Window address with replicated borders
    always_comb
    begin
        ys = SW'(out_row_reg) + SW'(cmd.wy) - SW'(HALF);
        xs = SW'(out_col_reg) + SW'(cmd.wx) - SW'(HALF);

        if (ys[SW-1])
        begin
            ycl = '0;
        end
        else if (ys >= $signed(SW'(eff_h)))
        begin
            ycl = eff_h - 1'b1;
        end
        else
        begin
            ycl = ys[DIM_W-1:0];
        end

        if (xs[SW-1])
        begin
            xcl = '0;
        end
        else if (xs >= $signed(SW'(eff_w)))
        begin
            xcl = eff_w - 1'b1;
        end
        else
        begin
            xcl = xs[DIM_W-1:0];
        end

        // The clamped row lies within HALF rows of the output row, so one wrap is enough.
        rt = RT_W'(out_ring_reg) + RT_W'(ycl) - RT_W'(out_row_reg);
        if (rt[RT_W-1])
        begin
            rd_ring = RING_W'(rt + RT_W'(RING));
        end
        else if (rt >= $signed(RT_W'(RING)))
        begin
            rd_ring = RING_W'(rt - RT_W'(RING));
        end
        else
        begin
            rd_ring = RING_W'(rt);
        end
    end

    assign rd_addr = ADDR_W'(rd_ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xcl);
    assign wr_addr = ADDR_W'(in_ring_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_reg);

    // Row store
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_addr] <= req.pixel;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
        end
    end

    // Insertion into the sorted window: the entries above the new value move up one place.
    always_comb
    begin
        for (int i = 0; i < NWIN; i++)
        begin
            gt[i] = (CNT_W'(i) < fill_reg) && (win_reg[i] > rd_data_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NWIN; i++)
        begin
            if ((CNT_W'(i) < fill_reg) && !gt[i])
            begin
                win_next[i] = win_reg[i];
            end
            else if (i > 0 && gt[(i > 0) ? i - 1 : 0])
            begin
                win_next[i] = win_reg[(i > 0) ? i - 1 : 0];
            end
            else
            begin
                win_next[i] = rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < NWIN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.win_clear)
        begin
            fill_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            fill_reg <= fill_reg + 1'b1;
            for (int i = 0; i < NWIN; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Trimmed sum, one sorted entry per cycle
    assign keep_lo = IDX_W'(trim);
    assign keep_hi = IDX_W'(NWIN - 1) - IDX_W'(trim);
    assign keep    = (cmd.sum_idx >= keep_lo) && (cmd.sum_idx <= keep_hi);
    assign divisor = DIV_W'(NWIN) - (DIV_W'(trim) << 1);

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clear)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_en && keep)
        begin
            sum_reg <= sum_reg + SUM_W'(win_reg[cmd.sum_idx]);
        end
    end

    atm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg.value        <= quotient[PIX_W-1:0];
            res_reg.end_of_frame <= last_out;
        end
    end

    assign res           = res_reg;
    assign res_valid     = res_valid_reg;
    assign stat.div_busy = div_busy;
    assign stat.out_full = res_valid_reg;

endmodule

[hdl/atm_ctrl.sv]
// Controller: sequences window gathering, summing, division and output load.
`timescale 1ns / 1ps

module atm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output atm_pkg::ctrl_cmd_t cmd,
    input  atm_pkg::dp_stat_t  stat
);
    import atm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GATHER = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_DIVGO  = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_HOLD   = 3'd6;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [WPOS_W-1:0] wy_reg;
    logic [WPOS_W-1:0] wy_next;
    logic [WPOS_W-1:0] wx_reg;
    logic [WPOS_W-1:0] wx_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        wy_next    = wy_reg;
        wx_next    = wx_reg;
        idx_next   = idx_reg;
        cmd.accept = accept;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && stat.emit_req)
                begin
                    cmd.win_clear = 1'b1;
                    wy_next       = '0;
                    wx_next       = '0;
                    state_next    = S_GATHER;
                end
            end
            S_GATHER:
            begin
                cmd.rd_en = 1'b1;
                cmd.wy    = wy_reg;
                cmd.wx    = wx_reg;
                if (wx_reg == WPOS_W'(WIN - 1))
                begin
                    wx_next = '0;
                    if (wy_reg == WPOS_W'(WIN - 1))
                    begin
                        state_next = S_RDWAIT;
                    end
                    else
                    begin
                        wy_next = wy_reg + 1'b1;
                    end
                end
                else
                begin
                    wx_next = wx_reg + 1'b1;
                end
            end
            S_RDWAIT:
            begin
                // The last read value is inserted into the window in this cycle.
                cmd.sum_clear = 1'b1;
                idx_next      = '0;
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en  = 1'b1;
                cmd.sum_idx = idx_reg;
                if (idx_reg == IDX_W'(NWIN - 1))
                begin
                    state_next = S_DIVGO;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    if (!stat.out_full)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wy_reg    <= '0;
            wx_reg    <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wy_reg    <= wy_next;
            wx_reg    <= wx_next;
            idx_reg   <= idx_next;
        end
    end

    a_idle_div_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !stat.div_busy)
        else $error("divider busy while controller idle");

    a_load_into_empty : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !stat.out_full)
        else $error("output loaded while a result is still waiting");

    a_load_fills : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> stat.out_full)
        else $error("output register not full after load");

    a_gather_cause : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GATHER && $past(state_reg) == S_IDLE)
            |-> $past(accept && stat.emit_req))
        else $error("window gathering started without an emitting request");

endmodule

[hdl/alpha_trimmed_mean_filter.sv]
// Top level of the 5x5 alpha-trimmed mean filter.
//
// Pixels of a frame arrive in raster order on the req channel (valid/ready); cmd 0 pushes
// a pixel, cmd 1 drains one pending output once the whole frame has been pushed. Results
// leave on the res channel in raster order, end_of_frame marking the last pixel.
// half_trim, active_width and active_height sit on the APB port at byte addresses 0, 4, 8.
// A request that produces a result keeps the controller busy for 25 reads of the row
// store (one port read per cycle, inserted into a sorted window), a trimmed sum over
// the sorted entries and a restoring division; the result then sits in the output
// register. A new request is taken while that result waits; if it also produces a
// result, the block holds it until the receiver takes the earlier one.
// Reset clears the registers to their defaults and the position counters to the start
// of a frame; the row store needs no clearing, as every entry is written before it is read.
`timescale 1ns / 1ps

module alpha_trimmed_mean_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [atm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  atm_pkg::in_item_t           req,
    output logic                        res_valid,
    input  logic                        res_ready,
    output atm_pkg::out_item_t          res
);
    import atm_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign pready = 1'b1;

    atm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    atm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .req       (req),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[dv/atm_checker.sv]
// Checker that predicts and compares the filtered pixels of the trimmed mean filter.
`timescale 1ns / 1ps

module atm_checker
    import atm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    input  logic                req_valid,
    input  logic                req_ready,
    input  in_item_t            req,
    input  logic                res_valid,
    input  logic                res_ready,
    input  out_item_t           res,
    output int                  fails,
    output int                  pending,
    output int                  pixels_seen
);

    logic [PIX_W-1:0] line_ring [MEM_DEPTH];
    out_item_t        pixel_queue [$];
    int unsigned      trim_reg, width_reg, height_reg;
    int unsigned      in_col, in_row, out_col, out_row;
    int               fail_cnt, seen_cnt;

    function automatic int unsigned eff_w();
        if (width_reg < MIN_DIM) return MIN_DIM;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    endfunction

    function automatic int unsigned clip(int v, int unsigned n);
        if (v < 0) return 0;
        if (v >= int'(n)) return n - 1;
        return v;
    endfunction

    function automatic void reset_positions();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // Builds the next output pixel and advances the output position.
    function automatic out_item_t trimmed_pixel(int unsigned w, int unsigned h);
        int          vals [NWIN];
        int          n, j, v, t, acc;
        int unsigned y, x;
        out_item_t   o;
        n = 0;
        for (int dy = -HALF; dy <= HALF; dy++)
        begin
            y = clip(int'(out_row) + dy, h);
            for (int dx = -HALF; dx <= HALF; dx++)
            begin
                x = clip(int'(out_col) + dx, w);
                vals[n] = line_ring[(y % RING) * MAX_WIDTH + x];
                n++;
            end
        end
        for (int i = 1; i < NWIN; i++)
        begin
            v = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > v)
            begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = v;
        end
        t = (trim_reg > TRIM_MAX) ? TRIM_MAX : trim_reg;
        acc = 0;
        for (int i = t; i < NWIN - t; i++)
            acc += vals[i];
        o.value = PIX_W'(acc / (NWIN - 2 * t));
        o.end_of_frame = (out_row == h - 1) && (out_col == w - 1);
        if (o.end_of_frame)
            reset_positions();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return o;
    endfunction

    function automatic void predict_request(in_item_t it);
        int unsigned w, h, lag, pushed, oq;
        w   = eff_w();
        h   = eff_h();
        lag = HALF * w + HALF;
        if (out_row >= h || in_row > h)
            reset_positions();
        if (it.cmd == CMD_PUSH)
        begin
            if (in_row >= h)
                return;
            if (in_col >= w)
                in_col = 0;
            line_ring[(in_row % RING) * MAX_WIDTH + in_col] = it.pixel;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            pushed = (in_row >= h) ? h * w : in_row * w + in_col;
            oq = out_row * w + out_col;
            if (pushed >= oq + lag + 1)
                pixel_queue.push_back(trimmed_pixel(w, h));
        end
        else if (in_row >= h)
            pixel_queue.push_back(trimmed_pixel(w, h));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg   = 0;
            width_reg  = MAX_WIDTH;
            height_reg = MAX_WIDTH;
            reset_positions();
            pixel_queue.delete();
            fail_cnt   = 0;
            seen_cnt   = 0;
            foreach (line_ring[i])
                line_ring[i] = '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                seen_cnt++;
                if (pixel_queue.size() == 0)
                begin
                    fail_cnt++;
                    $error("unexpected result value=%0d end_of_frame=%0d",
                           res.value, res.end_of_frame);
                end
                else
                begin
                    if (res.value !== pixel_queue[0].value)
                    begin
                        fail_cnt++;
                        $error("value: expected %0d, actual %0d",
                               pixel_queue[0].value, res.value);
                    end
                    if (res.end_of_frame !== pixel_queue[0].end_of_frame)
                    begin
                        fail_cnt++;
                        $error("end_of_frame: expected %0d, actual %0d",
                               pixel_queue[0].end_of_frame, res.end_of_frame);
                    end
                    void'(pixel_queue.pop_front());
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_HALF_TRIM:
                        trim_reg = pwdata[TRIM_W-1:0];
                    REG_ACTIVE_WIDTH:
                    begin
                        width_reg = pwdata[DIM_W-1:0];
                        reset_positions();
                    end
                    REG_ACTIVE_HEIGHT:
                    begin
                        height_reg = pwdata[DIM_W-1:0];
                        reset_positions();
                    end
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
                predict_request(req);
        end
        fails       <= fail_cnt;
        pending     <= pixel_queue.size();
        pixels_seen <= seen_cnt;
    end

endmodule

[dv/alpha_trimmed_mean_filter_test.sv]
// Top of the trimmed mean filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module alpha_trimmed_mean_filter_test;
    import atm_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_NONE = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               req_valid = 1'b0;
    logic               req_ready;
    in_item_t           req = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    out_item_t          res;

    int fails, pending, pixels_seen;
    int requests_sent = 0;
    int frames_sent = 0;
    bit quiet = 1'b0;
    bit hold_go = 1'b0;
    int unsigned cur_w = MAX_WIDTH, cur_h = MAX_WIDTH;

    alpha_trimmed_mean_filter dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    atm_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .fails(fails), .pending(pending), .pixels_seen(pixels_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: a random stall per result, plus one long hold-off on demand.
    initial
    begin
        int stall, hold_left;
        stall = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
                stall = quiet ? 0 : $urandom_range(0, 9);
            if (hold_go)
            begin
                hold_go = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    task automatic send_request(logic cmd, logic [PIX_W-1:0] pix);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{cmd: cmd, pixel: pix};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_frame(int unsigned trim, int unsigned w, int unsigned h);
        wait_idle();
        reg_write(REG_HALF_TRIM, trim);
        reg_write(REG_ACTIVE_WIDTH, w);
        reg_write(REG_ACTIVE_HEIGHT, h);
        w = w % 1024;
        h = h % 1024;
        cur_w = (w < MIN_DIM) ? MIN_DIM : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        cur_h = (h < MIN_DIM) ? MIN_DIM : h;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(int style, int n);
        case (style)
            0: return PIX_W'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return PIX_W'(n * 3 + $urandom_range(0, 7));
        endcase
    endfunction

    // One frame: pushes, then drains; when noisy, a little drain noise and at times a stray push once complete.
    task automatic send_frame(bit noisy);
        int style, lag;
        style = $urandom_range(0, 2);
        lag = HALF * cur_w + HALF;
        for (int n = 0; n < cur_w * cur_h; n++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_request(CMD_DRAIN, PIX_W'($urandom));
            send_request(CMD_PUSH, pick_pixel(style, n));
        end
        if (noisy && $urandom_range(0, 3) == 0)
            send_request(CMD_PUSH, PIX_W'($urandom));
        for (int n = 0; n < lag; n++)
            send_request(CMD_DRAIN, PIX_W'($urandom));
        frames_sent++;
    endtask

    initial
    begin
        int unsigned trim, w, h, cut;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame: drain before any push, extremes, push after completion.
        set_frame(0, 3, 3);
        send_request(CMD_DRAIN, 8'h00);
        for (int n = 0; n < 9; n++)
            send_request(CMD_PUSH, (n % 2) ? 8'hFF : 8'h00);
        send_request(CMD_PUSH, 8'h5A);
        for (int n = 0; n < 8; n++)
            send_request(CMD_DRAIN, 8'hFF);
        send_request(CMD_DRAIN, 8'h00);
        frames_sent++;
        set_frame(TRIM_MAX, 3, 3);
        send_frame(1'b0);
        set_frame(15, 0, 0);
        send_frame(1'b0);

        // Widest frame, cut short after its first outputs and dropped by rewriting the width.
        set_frame(7, 1023, 3);
        for (int n = 0; n < 1100; n++)
            send_request(CMD_PUSH, PIX_W'($urandom));
        wait_idle();
        reg_write(REG_ACTIVE_WIDTH, 32'd1023);

        // Tall narrow frame with a long receiver hold-off near its start.
        set_frame(5, 3, 100);
        hold_go = 1'b1;
        send_frame(1'b1);
        wait_idle();
        reg_write(REG_NONE, 32'hFFFF_FFFF);

        while (requests_sent < 1750)
        begin
            trim = $urandom_range(0, 15);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            quiet = ($urandom_range(0, 5) == 0);
            set_frame(trim, w, h);
            if ($urandom_range(0, 6) == 0)
            begin
                // Broken frame, dropped by rewriting the width.
                cut = $urandom_range(1, cur_w * cur_h - 1);
                for (int n = 0; n < cut; n++)
                    send_request(CMD_PUSH, PIX_W'($urandom));
                wait_idle();
                reg_write(REG_ACTIVE_WIDTH, w);
            end
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 9) == 0)
                    hold_go = 1'b1;
                send_frame(1'b1);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end
        quiet = 1'b0;

        wait_idle();
        $display("Covered %0d requests and %0d checked pixels over %0d frames,",
                 requests_sent, pixels_seen, frames_sent);
        $display("with trims 0 to 15, widths 3 to 512, heights 3 to 100, broken frames and a long stall.");
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/atm_pkg.sv
hdl/atm_div.sv
hdl/atm_datapath.sv
hdl/atm_ctrl.sv
hdl/alpha_trimmed_mean_filter.sv
dv/atm_checker.sv
dv/alpha_trimmed_mean_filter_test.sv
